// ----- design/sfds_pkg.sv -----
// Shared types, constants and helper functions of the speed filter derivative shaper.
package sfds_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SPEED_W    = 32;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 31;
    localparam int DERIV_W    = 48;
    localparam int DIFF_W     = DERIV_W + 1;
    localparam int MUL_A_W    = 34;
    localparam int MUL_B_W    = 16;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W + 1;
    localparam int SPLIT_W    = 24;
    localparam int JACC_W     = 66;
    localparam int FRAC_W     = 16;

    localparam logic signed [JACC_W-1:0] MAX48_EXT = 66'sd140737488355327;
    localparam logic signed [JACC_W-1:0] MIN48_EXT = -66'sd140737488355328;
    localparam logic signed [DIFF_W-1:0] LIM47_POS = 49'sd140737488355328;
    localparam logic signed [DIFF_W-1:0] LIM47_NEG = -49'sd140737488355328;
    localparam logic signed [MUL_P_W-1:0] ROUND_HALF = 51'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_GAIN     = 3'd0,
        REG_RATE_SCALE      = 3'd1,
        REG_DEAD_OFFSET     = 3'd2,
        REG_BOOST_THRESHOLD = 3'd3,
        REG_BOOST_AMOUNT    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  filter_gain;
        logic [GAIN_W-1:0]  rate_scale;
        logic [LIMIT_W-1:0] dead_offset;
        logic [LIMIT_W-1:0] boost_threshold;
        logic [LIMIT_W-1:0] boost_amount;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        filter_gain:     16'd23671,
        rate_scale:      16'd333,
        dead_offset:     31'd2949120,
        boost_threshold: 31'd39321600,
        boost_amount:    31'd13107200
    };

    function automatic logic signed [DERIV_W-1:0] sat48(input logic signed [JACC_W-1:0] v);
        logic signed [DERIV_W-1:0] r;
        if (v > MAX48_EXT) begin
            r = MAX48_EXT[DERIV_W-1:0];
        end else if (v < MIN48_EXT) begin
            r = MIN48_EXT[DERIV_W-1:0];
        end else begin
            r = v[DERIV_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- design/sfds_cfg_regs.sv -----
// Configuration register file of the speed filter derivative shaper.
module sfds_cfg_regs
    import sfds_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (cfg_index)
                REG_FILTER_GAIN:     cfg_next.filter_gain     = cfg_data[GAIN_W-1:0];
                REG_RATE_SCALE:      cfg_next.rate_scale      = cfg_data[GAIN_W-1:0];
                REG_DEAD_OFFSET:     cfg_next.dead_offset     = cfg_data[LIMIT_W-1:0];
                REG_BOOST_THRESHOLD: cfg_next.boost_threshold = cfg_data[LIMIT_W-1:0];
                REG_BOOST_AMOUNT:    cfg_next.boost_amount    = cfg_data[LIMIT_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/sfds_mul.sv -----
// Shared signed by unsigned multiplier with a registered product.
module sfds_mul
    import sfds_pkg::*;
(
    input  logic                       aclk,
    input  logic signed [MUL_A_W-1:0]  op_a,
    input  logic        [MUL_B_W-1:0]  op_b,
    output logic signed [MUL_P_W-1:0]  prod
);

    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [MUL_P_W-1:0] prod_next;

    assign prod_next = MUL_P_W'(op_a) * MUL_P_W'($signed({1'b0, op_b}));

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ----- design/speed_filter_derivative_shaper.sv -----
// Top level: low-pass speed filter, acceleration and shaped jerk on one shared multiplier.
// Each speed request runs through a ten-step sequencer that uses one 34 by 17 bit multiplier
// four times (filter gain, acceleration scale, and the jerk scale split into two partial
// products), so a new request is accepted only after the last one has left the result step,
// which holds while the output register is still full. A finished result waits in the
// output register while the next request is accepted. The configuration port is always
// ready; registers should be written only while no request is in flight.
module speed_filter_derivative_shaper
    import sfds_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [SPEED_W-1:0]   s_speed_sample,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [SPEED_W-1:0]   m_raw_speed,
    output logic signed [SPEED_W-1:0]   m_filtered_speed,
    output logic signed [DERIV_W-1:0]   m_acceleration,
    output logic signed [DERIV_W-1:0]   m_jerk,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_FILT = 11'b000_0000_0010,
        ST_UPD  = 11'b000_0000_0100,
        ST_ACC  = 11'b000_0000_1000,
        ST_SAT  = 11'b000_0001_0000,
        ST_JLO  = 11'b000_0010_0000,
        ST_JHI  = 11'b000_0100_0000,
        ST_SUM  = 11'b000_1000_0000,
        ST_SH1  = 11'b001_0000_0000,
        ST_SH2  = 11'b010_0000_0000,
        ST_DONE = 11'b100_0000_0000
    } state_t;

    cfg_t cfg;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    logic signed [SPEED_W-1:0] x_reg, x_next;
    logic signed [SPEED_W-1:0] y_reg, y_next;
    logic signed [SPEED_W-1:0] ynew_reg, ynew_next;
    logic signed [SPEED_W:0]   dy_reg, dy_next;
    logic signed [DERIV_W-1:0] last_acc_reg, last_acc_next;
    logic signed [DERIV_W-1:0] acc_reg, acc_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic signed [JACC_W-1:0]  jacc_reg, jacc_next;
    logic signed [DERIV_W-1:0] jerk_reg, jerk_next;

    logic signed [SPEED_W-1:0] m_raw_reg, m_raw_next;
    logic signed [SPEED_W-1:0] m_filt_reg, m_filt_next;
    logic signed [DERIV_W-1:0] m_acc_reg, m_acc_next;
    logic signed [DERIV_W-1:0] m_jerk_reg, m_jerk_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic        [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;

    logic signed [MUL_P_W-1:0]        rnd;
    logic signed [MUL_P_W-FRAC_W-1:0] step;
    logic signed [SPEED_W+3:0]        ysum;
    logic signed [SPEED_W-1:0]        yclamp;
    logic signed [DERIV_W-1:0]        acc_sat;
    logic signed [DIFF_W-1:0]         diff_raw;
    logic signed [JACC_W-1:0]         offset_ext;
    logic signed [JACC_W-1:0]         thresh_ext;
    logic signed [JACC_W-1:0]         amount_ext;
    logic signed [JACC_W-1:0]         boosted;
    logic                             out_free;

    sfds_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfds_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    always_comb begin
        mul_a = '0;
        mul_b = cfg.rate_scale;
        case (state_reg)
            ST_FILT: begin
                mul_a = MUL_A_W'(x_reg) - MUL_A_W'(y_reg);
                mul_b = cfg.filter_gain;
            end
            ST_ACC:  mul_a = MUL_A_W'(dy_reg);
            ST_JLO:  mul_a = $signed({{(MUL_A_W-SPLIT_W){1'b0}}, diff_reg[SPLIT_W-1:0]});
            ST_JHI:  mul_a = MUL_A_W'($signed(diff_reg[DIFF_W-1:SPLIT_W]));
            default: mul_a = '0;
        endcase
    end

    assign rnd    = prod + ROUND_HALF;
    assign step   = rnd[MUL_P_W-1:FRAC_W];
    assign ysum   = (SPEED_W+4)'(y_reg) + (SPEED_W+4)'(step);
    assign yclamp = (ysum > (SPEED_W+4)'(36'sh07FFFFFFF)) ? 32'sh7FFFFFFF :
                    (ysum < -(SPEED_W+4)'(36'sh080000000)) ? 32'sh80000000 :
                    ysum[SPEED_W-1:0];

    assign acc_sat  = sat48(JACC_W'(prod));
    assign diff_raw = DIFF_W'(acc_sat) - DIFF_W'(last_acc_reg);

    assign offset_ext = $signed({{(JACC_W-LIMIT_W){1'b0}}, cfg.dead_offset});
    assign thresh_ext = $signed({{(JACC_W-LIMIT_W){1'b0}}, cfg.boost_threshold});
    assign amount_ext = $signed({{(JACC_W-LIMIT_W){1'b0}}, cfg.boost_amount});
    assign boosted    = (jacc_reg > thresh_ext)  ? jacc_reg + amount_ext :
                        (jacc_reg < -thresh_ext) ? jacc_reg - amount_ext : jacc_reg;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        x_next        = x_reg;
        y_next        = y_reg;
        ynew_next     = ynew_reg;
        dy_next       = dy_reg;
        last_acc_next = last_acc_reg;
        acc_next      = acc_reg;
        diff_next     = diff_reg;
        jacc_next     = jacc_reg;
        jerk_next     = jerk_reg;
        m_raw_next    = m_raw_reg;
        m_filt_next   = m_filt_reg;
        m_acc_next    = m_acc_reg;
        m_jerk_next   = m_jerk_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    x_next     = s_speed_sample;
                    state_next = ST_FILT;
                end
            end
            ST_FILT: state_next = ST_UPD;
            ST_UPD: begin
                ynew_next  = yclamp;
                dy_next    = (SPEED_W+1)'(yclamp) - (SPEED_W+1)'(y_reg);
                state_next = ST_ACC;
            end
            ST_ACC: state_next = ST_SAT;
            ST_SAT: begin
                acc_next = acc_sat;
                if (diff_raw > LIM47_POS) begin
                    diff_next = LIM47_POS;
                end else if (diff_raw < LIM47_NEG) begin
                    diff_next = LIM47_NEG;
                end else begin
                    diff_next = diff_raw;
                end
                state_next = ST_JLO;
            end
            ST_JLO: state_next = ST_JHI;
            ST_JHI: begin
                jacc_next  = JACC_W'(prod);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                jacc_next  = jacc_reg + (JACC_W'(prod) <<< SPLIT_W);
                state_next = ST_SH1;
            end
            ST_SH1: begin
                if (jacc_reg > offset_ext) begin
                    jacc_next = jacc_reg - offset_ext;
                end else if (jacc_reg < -offset_ext) begin
                    jacc_next = jacc_reg + offset_ext;
                end
                state_next = ST_SH2;
            end
            ST_SH2: begin
                jerk_next  = sat48(boosted);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_raw_next    = x_reg;
                    m_filt_next   = ynew_reg;
                    m_acc_next    = acc_reg;
                    m_jerk_next   = jerk_reg;
                    y_next        = ynew_reg;
                    last_acc_next = acc_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            y_reg        <= '0;
            last_acc_reg <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            y_reg        <= y_next;
            last_acc_reg <= last_acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        ynew_reg   <= ynew_next;
        dy_reg     <= dy_next;
        acc_reg    <= acc_next;
        diff_reg   <= diff_next;
        jacc_reg   <= jacc_next;
        jerk_reg   <= jerk_next;
        m_raw_reg  <= m_raw_next;
        m_filt_reg <= m_filt_next;
        m_acc_reg  <= m_acc_next;
        m_jerk_reg <= m_jerk_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign cfg_ready        = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_raw_speed      = m_raw_reg;
    assign m_filtered_speed = m_filt_reg;
    assign m_acceleration   = m_acc_reg;
    assign m_jerk           = m_jerk_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> ##10 (state_reg == ST_DONE))
        else $error("Sequencer did not reach the result step on time.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=>
        (m_valid && m_filtered_speed == y_reg && m_acceleration == last_acc_reg))
        else $error("Filter state and delivered result disagree.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !out_free) |=> (state_reg == ST_DONE))
        else $error("Result step left while the output register was busy.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_DONE) |=> $stable(y_reg) && $stable(last_acc_reg))
        else $error("Filter state changed outside the result step.");
`endif

endmodule
